>>> hdl/segment_heap_allocator_macros.svh
// Assertion macros for the segment heap allocator.
// Used by the top level; no other dependencies.
`ifndef SEGMENT_HEAP_ALLOCATOR_MACROS_SVH
`define SEGMENT_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define SHA_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define SHA_ASSERT_IMP(label, clk, rst, a, c)
`define SHA_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

>>> hdl/sha_pkg.sv
// Package for the segment heap allocator: payload structs, codes and constants.
// No dependencies.
`default_nettype none
package sha_pkg;
   localparam int MAX_SEGMENTS_DEF = 32;
   localparam int HEAP_BYTES_DEF   = 65536;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NEXT  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_NOSPACE = 2'd2;
   localparam logic [1:0] ST_BADFREE = 2'd3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] CSR_FIT_MODE   = 2'd0;
   localparam logic [1:0] CSR_HEAP_LIMIT = 2'd1;
   localparam logic [1:0] CSR_HEADER     = 2'd2;

   typedef struct packed {
      logic        req_type;
      logic [16:0] req_size;
      logic [15:0] free_addr;
   } req_type_t_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] data_addr;
      logic        was_reused;
      logic        grew_heap;
      logic        did_split;
      logic [1:0]  merges_done;
      logic [5:0]  segments_scanned;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic [15:0] start;
      logic [16:0] size;
      logic        free;
      logic        dirty;
   } seg_type;

   // chain control shared by all cells
   typedef enum logic [1:0] {
      SH_HOLD  = 2'd0,
      SH_RIGHT = 2'd1,
      SH_LEFT  = 2'd2,
      SH_ROT   = 2'd3
   } shift_type;
endpackage
`default_nettype wire

>>> hdl/sha_cell.sv
// One slot of the segment chain: holds an entry, can take from either neighbour.
// Depends on sha_pkg.
`default_nettype none
module sha_cell (
   input  wire logic              clock,
   input  wire sha_pkg::shift_type op,
   input  wire logic              load,
   input  wire sha_pkg::seg_type  load_val,
   input  wire sha_pkg::seg_type  from_left,
   input  wire sha_pkg::seg_type  from_right,
   output sha_pkg::seg_type       q
);
   sha_pkg::seg_type q_ff, q_in;

   always_comb begin
      q_in = q_ff;
      if (load) begin
         q_in = load_val;
      end else begin
         case (op)
            sha_pkg::SH_RIGHT: q_in = from_left;
            sha_pkg::SH_LEFT:  q_in = from_right;
            sha_pkg::SH_ROT:   q_in = from_right;
            default:           q_in = q_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;
endmodule
`default_nettype wire

>>> hdl/segment_heap_allocator.sv
// Segment heap allocator. An address-ordered table of segments lives in a chain
// of cells that rotates one place per cycle past a head cell; the sequencer
// examines one segment per cycle as it passes. A request is handled one at a
// time. After acceptance, one full revolution of the chain covers the search
// (a zero-size alloc skips it), followed by a decide step in S_DECIDE. Then come
// the table updates: a split insert runs S_INS then S_INS2, an in-place grant or
// a heap growth runs S_RM2, and a free runs S_FREE per merge check, S_RM per
// removal and S_RM2 for the final write. No space, a bad free and a zero size go
// straight to S_DONE, which moves the result into the output register once that
// register can take it. A result held by rsp_stall lets the next request run
// until its own result is due. req_stall is also raised while a register write
// is offered.
// Depends on sha_pkg and segment_heap_allocator_macros.svh.
`default_nettype none
`include "segment_heap_allocator_macros.svh"
module segment_heap_allocator #(
   parameter int MAX_SEGMENTS = sha_pkg::MAX_SEGMENTS_DEF,
   parameter int HEAP_BYTES   = sha_pkg::HEAP_BYTES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire sha_pkg::req_type_t_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output sha_pkg::rsp_type             rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [16:0]             csr_wdata
);
   localparam int N  = MAX_SEGMENTS;
   localparam int IW = $clog2(N);
   localparam int CW = $clog2(N + 1);
   localparam logic [16:0] HEAP_LIM =
      (HEAP_BYTES > 65536) ? 17'd65536 : 17'(HEAP_BYTES);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_INS, S_INS2, S_FREE, S_RM, S_RM2, S_DONE
   } state_type;

   state_type state_ff;
   // Scan rotates the chain. The entry at cell 0 has logical index pos_ff.
   // Outside scan the chain is at rotation zero (cell i holds entry i).
   sha_pkg::seg_type cell_q [N];
   sha_pkg::shift_type op;
   logic [N-1:0] load;
   sha_pkg::seg_type load_val;
   logic [IW-1:0] tgt;     // cell for left/right shifts: cells >= tgt move left, cells > tgt move right

   logic [1:0]  fit_mode_ff;
   logic [16:0] heap_limit_ff;
   logic [6:0]  header_ff;
   logic [CW-1:0] count_ff, cursor_ff, pos_ff, k_ff, rm_ff;
   logic [16:0] top_ff;
   logic        found_ff, stop_ff, rtype_ff;
   logic [17:0] need_ff;
   logic [15:0] faddr_ff;
   sha_pkg::seg_type ksel_ff, cur_ff, rem_ff;
   logic        left_pass_ff;
   sha_pkg::rsp_type res_ff;
   sha_pkg::rsp_type rsp_ff;
   logic        rsp_valid_ff;

   sha_pkg::seg_type head, nxt, prv;
   logic in_range;
   logic [18:0] grow_end;
   logic [16:0] heap_cap;
   logic split_ok, grow_ok, rsp_load;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         sha_pkg::seg_type fl, fr;
         sha_pkg::shift_type cop;
         assign fl  = cell_q[(g + N - 1) % N];
         assign fr  = cell_q[(g + 1) % N];
         always_comb begin
            cop = op;
            if ((op == sha_pkg::SH_RIGHT || op == sha_pkg::SH_LEFT) && IW'(g) < tgt)
               cop = sha_pkg::SH_HOLD;
            if (op == sha_pkg::SH_RIGHT && IW'(g) == tgt) cop = sha_pkg::SH_HOLD;
         end
         sha_cell u_cell (
            .clock(clock), .op(cop), .load(load[g]), .load_val(load_val),
            .from_left(fl), .from_right(fr), .q(cell_q[g])
         );
      end
   endgenerate

   assign head      = cell_q[0];
   assign nxt       = cell_q[IW'(k_ff + 1'b1)];
   assign prv       = cell_q[IW'(k_ff - 1'b1)];
   assign in_range  = pos_ff < count_ff;
   assign grow_end  = 19'(top_ff) + 19'(header_ff) + 19'(need_ff);
   assign heap_cap  = (heap_limit_ff < HEAP_LIM) ? heap_limit_ff : HEAP_LIM;
   assign split_ok  = (19'(ksel_ff.size) >= 19'(need_ff) + 19'(header_ff) + 19'd4) &&
                      (count_ff < CW'(N));
   assign grow_ok   = (count_ff < CW'(N)) && (grow_end <= 19'(heap_cap));
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      op = sha_pkg::SH_HOLD;
      load = '0;
      load_val = cur_ff;
      tgt = '0;
      case (state_ff)
         S_SCAN: op = sha_pkg::SH_ROT;
         S_INS: begin
            // open a gap at k+1; the granted part goes back into cell k
            op = sha_pkg::SH_RIGHT;
            tgt = IW'(k_ff + 1'b1);
            load[k_ff[IW-1:0]] = 1'b1;
         end
         S_INS2: begin
            load[IW'(k_ff + 1'b1)] = 1'b1;
            load_val = rem_ff;
         end
         S_RM: begin
            op = sha_pkg::SH_LEFT;
            tgt = rm_ff[IW-1:0];
         end
         S_RM2: load[k_ff[IW-1:0]] = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fit_mode_ff <= sha_pkg::FIT_FIRST;
         heap_limit_ff <= 17'd65536;
         header_ff <= 7'd24;
         count_ff <= '0;
         top_ff <= '0;
         cursor_ff <= CW'(N);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_ff <= res_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sha_pkg::CSR_FIT_MODE:   fit_mode_ff <= csr_wdata[1:0];
               sha_pkg::CSR_HEAP_LIMIT: heap_limit_ff <= csr_wdata;
               sha_pkg::CSR_HEADER:     header_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  rtype_ff <= req_data.req_type;
                  need_ff <= (18'(req_data.req_size) + 18'd3) & ~18'd3;
                  faddr_ff <= req_data.free_addr;
                  res_ff <= '0;
                  found_ff <= 1'b0;
                  stop_ff <= 1'b0;
                  left_pass_ff <= 1'b0;
                  pos_ff <= '0;
                  // zero size skips the scan
                  if (req_data.req_type == sha_pkg::REQ_ALLOC && req_data.req_size == '0)
                     state_ff <= S_DECIDE;
                  else
                     state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // head holds entry pos_ff
               if (in_range && !stop_ff) begin
                  if (rtype_ff == sha_pkg::REQ_FREE) begin
                     if (head.start == faddr_ff) begin
                        found_ff <= 1'b1; stop_ff <= 1'b1; k_ff <= pos_ff;
                        ksel_ff <= head;
                     end
                  end else if (fit_mode_ff != sha_pkg::FIT_NEXT ||
                               cursor_ff >= count_ff || pos_ff >= cursor_ff) begin
                     res_ff.segments_scanned <= res_ff.segments_scanned + 6'd1;
                     if (head.free && head.size >= need_ff) begin
                        case (fit_mode_ff)
                           sha_pkg::FIT_BEST: begin
                              if (!found_ff || head.size < ksel_ff.size) begin
                                 found_ff <= 1'b1; k_ff <= pos_ff; ksel_ff <= head;
                              end
                              if (head.size == need_ff) stop_ff <= 1'b1;
                           end
                           sha_pkg::FIT_WORST: begin
                              if (!found_ff || head.size > ksel_ff.size) begin
                                 found_ff <= 1'b1; k_ff <= pos_ff; ksel_ff <= head;
                              end
                           end
                           default: begin
                              found_ff <= 1'b1; k_ff <= pos_ff; ksel_ff <= head;
                              stop_ff <= 1'b1;
                           end
                        endcase
                     end
                  end
               end
               pos_ff <= pos_ff + 1'b1;
               if (pos_ff == CW'(N - 1)) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (rtype_ff == sha_pkg::REQ_FREE) begin
                  if (!found_ff || ksel_ff.free) begin
                     res_ff.status <= sha_pkg::ST_BADFREE;
                     state_ff <= S_DONE;
                  end else begin
                     cur_ff <= '{start: ksel_ff.start, size: ksel_ff.size,
                                 free: 1'b1, dirty: ksel_ff.dirty};
                     state_ff <= S_FREE;
                  end
               end else if (need_ff == '0) begin
                  res_ff.status <= sha_pkg::ST_ZERO;
                  state_ff <= S_DONE;
               end else if (found_ff) begin
                  res_ff.was_reused <= ksel_ff.dirty;
                  res_ff.data_addr <= ksel_ff.start;
                  if (fit_mode_ff == sha_pkg::FIT_NEXT) cursor_ff <= k_ff;
                  cur_ff <= '{start: ksel_ff.start,
                              size: split_ok ? 17'(need_ff) : ksel_ff.size,
                              free: 1'b0, dirty: 1'b1};
                  if (split_ok) begin
                     rem_ff <= '{start: 16'(19'(ksel_ff.start) + 19'(need_ff) +
                                            19'(header_ff)),
                                 size: 17'(19'(ksel_ff.size) - 19'(need_ff) -
                                           19'(header_ff)),
                                 free: 1'b1, dirty: ksel_ff.dirty};
                     res_ff.did_split <= 1'b1;
                     state_ff <= S_INS;
                  end else begin
                     state_ff <= S_RM2;
                  end
               end else begin
                  if (fit_mode_ff == sha_pkg::FIT_NEXT) cursor_ff <= CW'(N);
                  if (grow_ok) begin
                     res_ff.grew_heap <= 1'b1;
                     res_ff.data_addr <= 16'(top_ff + 17'(header_ff));
                     k_ff <= count_ff;
                     cur_ff <= '{start: 16'(top_ff + 17'(header_ff)), size: 17'(need_ff),
                                 free: 1'b0, dirty: 1'b1};
                     top_ff <= 17'(grow_end);
                     count_ff <= count_ff + 1'b1;
                     state_ff <= S_RM2;
                  end else begin
                     res_ff.status <= sha_pkg::ST_NOSPACE;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_INS: begin
               if (cursor_ff < count_ff && cursor_ff >= k_ff + 1'b1 &&
                   fit_mode_ff != sha_pkg::FIT_NEXT)
                  cursor_ff <= cursor_ff + 1'b1;
               count_ff <= count_ff + 1'b1;
               state_ff <= S_INS2;
            end
            S_INS2: state_ff <= S_DONE;
            S_FREE: begin
               // right neighbour first, then left
               if (!left_pass_ff && k_ff + 1'b1 < count_ff && nxt.free) begin
                  cur_ff <= '{start: cur_ff.start,
                              size: cur_ff.size + 17'(header_ff) + nxt.size,
                              free: 1'b1, dirty: cur_ff.dirty | nxt.dirty};
                  rm_ff <= k_ff + 1'b1;
                  res_ff.merges_done <= res_ff.merges_done + 2'd1;
                  state_ff <= S_RM;
               end else if (k_ff != '0 && prv.free) begin
                  cur_ff <= '{start: prv.start,
                              size: prv.size + 17'(header_ff) + cur_ff.size,
                              free: 1'b1, dirty: prv.dirty | cur_ff.dirty};
                  rm_ff <= k_ff;
                  k_ff <= k_ff - 1'b1;
                  res_ff.merges_done <= res_ff.merges_done + 2'd1;
                  left_pass_ff <= 1'b1;
                  state_ff <= S_RM;
               end else begin
                  state_ff <= S_RM2;
               end
            end
            S_RM: begin
               if (cursor_ff < count_ff && cursor_ff >= rm_ff && cursor_ff != '0)
                  cursor_ff <= cursor_ff - 1'b1;
               count_ff <= count_ff - 1'b1;
               if (left_pass_ff) begin
                  state_ff <= S_RM2;
               end else begin
                  left_pass_ff <= 1'b1;
                  state_ff <= S_FREE;
               end
            end
            S_RM2: state_ff <= S_DONE;
            S_DONE: begin
               if (rsp_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   `SHA_ASSERT_IMP(a_csr_idle, clock, reset, csr_valid && csr_ready, state_ff == S_IDLE)
   `SHA_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CW'(N))
   `SHA_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, req_stall)
   `SHA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
endmodule
`default_nettype wire

>>> verif/segment_heap_allocator_test.sv
// Self-checking testbench for the segment heap allocator: random alloc/free traffic
// under every fit policy, checked against a behavioural allocator model.
// Depends on sha_pkg and the segment_heap_allocator RTL.
`timescale 1ns / 1ps
module segment_heap_allocator_test;

   localparam int NSEG = 32;
   localparam int HEAP = 65536;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   sha_pkg::req_type_t_type   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   sha_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [1:0]                csr_index = '0;
   logic [16:0]               csr_wdata = '0;

   segment_heap_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // allocator model state
   logic [15:0] m_start [NSEG];
   logic [16:0] m_size [NSEG];
   logic        m_free [NSEG];
   logic        m_dirty [NSEG];
   int          m_count;
   int          m_top;
   int          m_cursor;
   logic [1:0]  m_mode;
   int          m_limit;
   int          m_hdr;

   sha_pkg::req_type_t_type pending_reqs[$];
   sha_pkg::rsp_type        awaited_rsps[$];
   int             errors = 0;
   bit             hold_rsp = 1'b0;
   bit             req_accepted = 1'b0;

   // live data addresses we handed out, for legal frees
   logic [15:0] live_addrs[$];

   function automatic void seg_insert(int k, int s, int z, logic fr, logic dt);
      if (m_count >= NSEG || k > m_count) return;
      for (int i = m_count; i > k; i--) begin
         m_start[i] = m_start[i-1]; m_size[i] = m_size[i-1];
         m_free[i] = m_free[i-1]; m_dirty[i] = m_dirty[i-1];
      end
      m_start[k] = 16'(s); m_size[k] = 17'(z); m_free[k] = fr; m_dirty[k] = dt;
      if (m_cursor < m_count && m_cursor >= k) m_cursor++;
      m_count++;
   endfunction

   function automatic void seg_remove(int r);
      if (r >= m_count) return;
      for (int i = r; i + 1 < m_count; i++) begin
         m_start[i] = m_start[i+1]; m_size[i] = m_size[i+1];
         m_free[i] = m_free[i+1]; m_dirty[i] = m_dirty[i+1];
      end
      if (m_cursor < m_count && m_cursor >= r && m_cursor > 0) m_cursor--;
      m_count--;
   endfunction

   function automatic sha_pkg::rsp_type allocate_or_release(sha_pkg::req_type_t_type rq);
      sha_pkg::rsp_type o;
      int need, k, first, lim, rem;
      bit found;
      o = '0;
      found = 0;
      k = 0;
      if (rq.req_type == sha_pkg::REQ_ALLOC) begin
         if (rq.req_size == 0) begin
            o.status = sha_pkg::ST_ZERO;
         end else begin
            need = (int'(rq.req_size) + 3) & ~3;
            first = 0;
            if (m_mode == sha_pkg::FIT_NEXT && m_cursor < m_count) first = m_cursor;
            for (int i = first; i < m_count; i++) begin
               o.segments_scanned++;
               if (!m_free[i] || m_size[i] < need) continue;
               if (m_mode == sha_pkg::FIT_BEST) begin
                  if (!found || m_size[i] < m_size[k]) begin found = 1; k = i; end
                  if (m_size[k] == need) break;
               end else if (m_mode == sha_pkg::FIT_WORST) begin
                  if (!found || m_size[i] > m_size[k]) begin found = 1; k = i; end
               end else begin
                  found = 1; k = i;
                  break;
               end
            end
            if (found) begin
               o.was_reused = m_dirty[k];
               if (m_size[k] >= need + m_hdr + 4 && m_count < NSEG) begin
                  rem = m_size[k] - need - m_hdr;
                  seg_insert(k + 1, m_start[k] + need + m_hdr, rem, 1'b1, m_dirty[k]);
                  m_size[k] = 17'(need);
                  o.did_split = 1'b1;
               end
               m_free[k] = 1'b0;
               m_dirty[k] = 1'b1;
               o.data_addr = m_start[k];
               if (m_mode == sha_pkg::FIT_NEXT) m_cursor = k;
            end else begin
               lim = m_limit < HEAP ? m_limit : HEAP;
               if (m_mode == sha_pkg::FIT_NEXT) m_cursor = NSEG;
               if (m_count < NSEG && m_top + m_hdr + need <= lim) begin
                  seg_insert(m_count, m_top + m_hdr, need, 1'b0, 1'b1);
                  m_top += m_hdr + need;
                  o.data_addr = 16'(m_top - need);
                  o.grew_heap = 1'b1;
               end else begin
                  o.status = sha_pkg::ST_NOSPACE;
               end
            end
         end
      end else begin
         for (int i = 0; i < m_count; i++) begin
            if (m_start[i] == rq.free_addr) begin found = 1; k = i; break; end
         end
         if (!found || m_free[k]) begin
            o.status = sha_pkg::ST_BADFREE;
         end else begin
            m_free[k] = 1'b1;
            if (k + 1 < m_count && m_free[k+1]) begin
               m_size[k] = 17'(m_size[k] + m_hdr + m_size[k+1]);
               m_dirty[k] = m_dirty[k] | m_dirty[k+1];
               seg_remove(k + 1);
               o.merges_done++;
            end
            if (k > 0 && m_free[k-1]) begin
               m_size[k-1] = 17'(m_size[k-1] + m_hdr + m_size[k]);
               m_dirty[k-1] = m_dirty[k-1] | m_dirty[k];
               seg_remove(k);
               o.merges_done++;
            end
         end
      end
      if (o.status != sha_pkg::ST_OK) o.data_addr = '0;
      return o;
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 60);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on input transfer, check on output transfer
   always @(posedge clock) begin
      req_accepted <= 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sha_pkg::rsp_type e;
            e = allocate_or_release(req_data);
            if (req_data.req_type == sha_pkg::REQ_ALLOC && e.status == sha_pkg::ST_OK)
               live_addrs.push_back(e.data_addr);
            awaited_rsps.push_back(e);
            req_accepted <= 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               $error("result transfer with nothing expected");
               errors++;
            end else begin
               sha_pkg::rsp_type e;
               e = awaited_rsps.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_data.status); errors++;
               end
               if (rsp_data.data_addr !== e.data_addr) begin
                  $error("data_addr exp %0d got %0d", e.data_addr, rsp_data.data_addr);
                  errors++;
               end
               if (rsp_data.was_reused !== e.was_reused) begin
                  $error("was_reused exp %0d got %0d", e.was_reused, rsp_data.was_reused);
                  errors++;
               end
               if (rsp_data.grew_heap !== e.grew_heap) begin
                  $error("grew_heap exp %0d got %0d", e.grew_heap, rsp_data.grew_heap);
                  errors++;
               end
               if (rsp_data.did_split !== e.did_split) begin
                  $error("did_split exp %0d got %0d", e.did_split, rsp_data.did_split);
                  errors++;
               end
               if (rsp_data.merges_done !== e.merges_done) begin
                  $error("merges_done exp %0d got %0d", e.merges_done, rsp_data.merges_done);
                  errors++;
               end
               if (rsp_data.segments_scanned !== e.segments_scanned) begin
                  $error("segments_scanned exp %0d got %0d", e.segments_scanned,
                         rsp_data.segments_scanned);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stall pattern, with a long hold-off when requested
   int stall_mode = 0;
   int hold_cycles = 0;
   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
         hold_cycles++;
      end else begin
         if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   task automatic csr_write(logic [1:0] idx, int val);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= val[16:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         sha_pkg::CSR_FIT_MODE:   m_mode = val[1:0];
         sha_pkg::CSR_HEAP_LIMIT: m_limit = val & 17'h1FFFF;
         default:                 m_hdr = val & 7'h7F;
      endcase
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || awaited_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic sha_pkg::req_type_t_type mk_alloc(int sz);
      sha_pkg::req_type_t_type r;
      r = '0;
      r.req_type = sha_pkg::REQ_ALLOC;
      r.req_size = sz[16:0];
      r.free_addr = 16'($urandom());
      return r;
   endfunction

   function automatic sha_pkg::req_type_t_type mk_free(int a);
      sha_pkg::req_type_t_type r;
      r.req_type = sha_pkg::REQ_FREE;
      r.req_size = 17'($urandom());
      r.free_addr = a[15:0];
      return r;
   endfunction

   // queues a random phase; most frees pick from handed-out addresses once available, the rest use random addresses
   task automatic random_phase(int n);
      int sz, pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
                 : $urandom_range(1, 600);
            pending_reqs.push_back(mk_alloc(sz));
         end else if (pick < 90 && live_addrs.size() > 0) begin
            int j;
            j = $urandom_range(0, live_addrs.size() - 1);
            pending_reqs.push_back(mk_free(live_addrs[j]));
            live_addrs.delete(j);
         end else begin
            pending_reqs.push_back(mk_free($urandom_range(0, 65535)));
         end
         // keep the queue short so frees see recent grants
         while (pending_reqs.size() > 4) @(posedge clock);
      end
   endtask

   initial begin
      m_count = 0; m_top = 0; m_cursor = NSEG;
      m_mode = sha_pkg::FIT_FIRST; m_limit = 65536; m_hdr = 24;
      for (int i = 0; i < NSEG; i++) begin
         m_start[i] = '0; m_size[i] = '0; m_free[i] = 1'b0; m_dirty[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes and special cases
      pending_reqs.push_back(mk_alloc(0));
      pending_reqs.push_back(mk_alloc(1));
      pending_reqs.push_back(mk_alloc(131071));
      pending_reqs.push_back(mk_alloc(65536));
      pending_reqs.push_back(mk_alloc(100));
      pending_reqs.push_back(mk_alloc(8));
      pending_reqs.push_back(mk_free(24));
      pending_reqs.push_back(mk_free(24));
      pending_reqs.push_back(mk_free(0));
      pending_reqs.push_back(mk_free(65535));
      pending_reqs.push_back(mk_alloc(4));
      pending_reqs.push_back(mk_alloc(40));
      drain();
      live_addrs.delete();
      for (int i = 0; i < m_count; i++)
         if (!m_free[i]) live_addrs.push_back(m_start[i]);

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1'b1;
      fork
         random_phase(20);
         begin
            wait (hold_cycles >= 300);
            hold_rsp = 1'b0;
         end
      join
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         csr_write(sha_pkg::CSR_FIT_MODE, ph % 4);
         case (ph)
            0: csr_write(sha_pkg::CSR_HEAP_LIMIT, 0);
            1: csr_write(sha_pkg::CSR_HEAP_LIMIT, 131071);
            2: csr_write(sha_pkg::CSR_HEAP_LIMIT, 2000);
            default: csr_write(sha_pkg::CSR_HEAP_LIMIT, $urandom_range(0, 131071));
         endcase
         case (ph)
            0: csr_write(sha_pkg::CSR_HEADER, 0);
            1: csr_write(sha_pkg::CSR_HEADER, 127);
            2: csr_write(sha_pkg::CSR_HEADER, 64);
            default: csr_write(sha_pkg::CSR_HEADER, $urandom_range(0, 127));
         endcase
         random_phase(210);
         drain();
      end
      if (errors == 0) $display("segment_heap_allocator regression: pass");
      else $display("segment_heap_allocator regression: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("segment_heap_allocator regression: fail");
      $finish;
   end
endmodule
